// ===== hw/rtl/dcsr_pkg.sv =====
`default_nettype none
package dcsr_pkg;

  localparam int SP_W    = 10;
  localparam int SAMP_W  = 10;
  localparam int BUS_W   = 16;
  localparam int CNT_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_REG  = 2'd2;
  localparam logic [1:0] KIND_BUS  = 2'd3;

  localparam logic [1:0] KEY_SEL    = 2'd0;
  localparam logic [1:0] KEY_UP     = 2'd1;
  localparam logic [1:0] KEY_DN     = 2'd2;
  localparam logic [1:0] KEY_RUN    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SP_TOP       = 2'd2;

  localparam logic [CNT_W-1:0] BLINK_PERIOD_RST = 16'd1000;
  localparam logic [CNT_W-1:0] AUTO_DELAY_RST   = 16'd10000;
  localparam logic [SP_W-1:0]  SP_TOP_RST       = 10'd500;

  localparam logic [BUS_W-1:0] BUS_ADDR_RUN = 16'd0;
  localparam logic [BUS_W-1:0] BUS_ADDR_SP0 = 16'd1;
  localparam logic [BUS_W-1:0] BUS_ADDR_SP1 = 16'd2;

  localparam logic [1:0] RUN_STOP  = 2'b01;
  localparam logic [1:0] RUN_START = 2'b10;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        key_code;
    logic [SAMP_W-1:0] sample_a;
    logic [SAMP_W-1:0] sample_b;
    logic [BUS_W-1:0]  bus_address;
    logic [BUS_W-1:0]  bus_data;
  } item_t;

  typedef struct packed {
    logic [SP_W-1:0] setpoint_out_a;
    logic [SP_W-1:0] setpoint_out_b;
    logic            running_a;
    logic            running_b;
    logic [9:0]      drive_a;
    logic [9:0]      drive_b;
    logic            adjusting_a;
    logic            adjusting_b;
    logic            selected;
    logic            cycling;
    logic            phase;
    logic [1:0]      save_request;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dual_channel_step_regulator_unit.sv =====
// Channel  Direction  Handshake              Beat
// in_      input      in_valid / in_ready    kind, key_code, samples, bus address/data
// out_     output     out_valid / out_ready  setpoints, run, drive, adjust, panel, save
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One result beat per input beat, one beat per cycle sustained while out_ready stays high.
// A result passes the input register, then the state update into the result register.
// cfg_ready is always high; registers take effect on the next item.
// rst_n is synchronous, active low; it restores register defaults and clears all state.
// A stalled out_ready holds the result and backs up into in_ready the same cycle.
`default_nettype none
module dual_channel_step_regulator_unit
  import dcsr_pkg::*;
#(
  parameter int DRIVE_MAX = 1023
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_kind,
  input  wire logic [1:0]            in_key_code,
  input  wire logic [SAMP_W-1:0]     in_sample_a,
  input  wire logic [SAMP_W-1:0]     in_sample_b,
  input  wire logic [BUS_W-1:0]      in_bus_address,
  input  wire logic [BUS_W-1:0]      in_bus_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SP_W-1:0]            out_setpoint_out_a,
  output logic [SP_W-1:0]            out_setpoint_out_b,
  output logic                       out_running_a,
  output logic                       out_running_b,
  output logic [9:0]                 out_drive_a,
  output logic [9:0]                 out_drive_b,
  output logic                       out_adjusting_a,
  output logic                       out_adjusting_b,
  output logic                       out_selected,
  output logic                       out_cycling,
  output logic                       out_phase,
  output logic [1:0]                 out_save_request,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    exec_en;
  cfg_wr_t cfg;
  result_t res_nxt;
  result_t res;

  assign in_item.kind        = in_kind;
  assign in_item.key_code    = in_key_code;
  assign in_item.sample_a    = in_sample_a;
  assign in_item.sample_b    = in_sample_b;
  assign in_item.bus_address = in_bus_address;
  assign in_item.bus_data    = in_bus_data;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign exec_en = item_valid && take;

  dcsr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (exec_en),
    .item_valid (item_valid),
    .item       (item)
  );

  dcsr_core #(
    .DRIVE_MAX (DRIVE_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .exec_en (exec_en),
    .item    (item),
    .res     (res_nxt)
  );

  dcsr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (exec_en),
    .res_in    (res_nxt),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_setpoint_out_a = res.setpoint_out_a;
  assign out_setpoint_out_b = res.setpoint_out_b;
  assign out_running_a      = res.running_a;
  assign out_running_b      = res.running_b;
  assign out_drive_a        = res.drive_a;
  assign out_drive_b        = res.drive_b;
  assign out_adjusting_a    = res.adjusting_a;
  assign out_adjusting_b    = res.adjusting_b;
  assign out_selected       = res.selected;
  assign out_cycling        = res.cycling;
  assign out_phase          = res.phase;
  assign out_save_request   = res.save_request;

endmodule
`default_nettype wire

// ===== hw/rtl/dcsr_in_stage.sv =====
`default_nettype none
module dcsr_in_stage
  import dcsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dcsr_core.sv =====
`default_nettype none
module dcsr_core
  import dcsr_pkg::*;
#(
  parameter int DRIVE_MAX = 1023
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  input  wire logic    exec_en,
  input  wire item_t   item,
  output result_t      res
);

  localparam int DRIVE_W = $clog2(DRIVE_MAX + 1);
  localparam logic [DRIVE_W-1:0] DRIVE_TOP = DRIVE_W'(DRIVE_MAX);

  logic [CNT_W-1:0] blink_period_r;
  logic [CNT_W-1:0] auto_delay_r;
  logic [SP_W-1:0]  sp_top_r;

  logic [SP_W-1:0]    sp_r    [2];
  logic [SP_W-1:0]    sp_nxt  [2];
  logic [1:0]         run_r, run_nxt;
  logic [DRIVE_W-1:0] drive_r   [2];
  logic [DRIVE_W-1:0] drive_nxt [2];
  logic [1:0]         adj_r, adj_nxt;
  logic               sel_r, sel_nxt;
  logic               cyc_r, cyc_nxt;
  logic               blink_r, blink_nxt;
  logic [CNT_W-1:0]   blink_cnt_r, blink_cnt_nxt;
  logic [CNT_W-1:0]   idle_cnt_r, idle_cnt_nxt;
  logic [1:0]         save;

  logic [CNT_W:0]     blink_inc;
  logic [CNT_W:0]     idle_inc;
  logic [SAMP_W-1:0]  samp [2];
  logic               bus_ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= BLINK_PERIOD_RST;
      auto_delay_r   <= AUTO_DELAY_RST;
      sp_top_r       <= SP_TOP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLINK_PERIOD: blink_period_r <= cfg.data;
        REG_AUTO_DELAY:   auto_delay_r   <= cfg.data;
        REG_SP_TOP:       sp_top_r       <= cfg.data[SP_W-1:0];
        default: ;
      endcase
    end
  end

  assign blink_inc = {1'b0, blink_cnt_r} + (CNT_W+1)'(1);
  assign idle_inc  = {1'b0, idle_cnt_r} + (CNT_W+1)'(1);
  assign samp[0]   = item.sample_a;
  assign samp[1]   = item.sample_b;
  assign bus_ch    = item.bus_address[1];

  always_comb begin
    sp_nxt        = sp_r;
    run_nxt       = run_r;
    drive_nxt     = drive_r;
    adj_nxt       = adj_r;
    sel_nxt       = sel_r;
    cyc_nxt       = cyc_r;
    blink_nxt     = blink_r;
    blink_cnt_nxt = blink_cnt_r;
    idle_cnt_nxt  = idle_cnt_r;
    save          = 2'b00;
    case (item.kind)
      KIND_TICK: begin
        if (blink_inc > {1'b0, blink_period_r}) begin
          blink_cnt_nxt = '0;
          blink_nxt     = !blink_r;
        end else begin
          blink_cnt_nxt = blink_inc[CNT_W-1:0];
        end
        if (run_r[0] && run_r[1] && !cyc_r) begin
          if (idle_inc > {1'b0, auto_delay_r}) begin
            cyc_nxt      = 1'b1;
            idle_cnt_nxt = '0;
          end else begin
            idle_cnt_nxt = idle_inc[CNT_W-1:0];
          end
        end
      end
      KIND_KEY: begin
        if (cyc_r) begin
          cyc_nxt = 1'b0;
        end else begin
          idle_cnt_nxt = '0;
          case (item.key_code)
            KEY_SEL: sel_nxt = !sel_r;
            KEY_UP: begin
              if (sp_r[sel_r] < sp_top_r) begin
                sp_nxt[sel_r] = sp_r[sel_r] + SP_W'(1);
                save[sel_r]   = 1'b1;
              end
            end
            KEY_DN: begin
              if (sp_r[sel_r] != '0) begin
                sp_nxt[sel_r] = sp_r[sel_r] - SP_W'(1);
                save[sel_r]   = 1'b1;
              end
            end
            default: run_nxt[sel_r] = !run_r[sel_r];
          endcase
        end
      end
      KIND_REG: begin
        for (int c = 0; c < 2; c++) begin
          if (run_r[c]) begin
            if (sp_r[c] < samp[c]) begin
              if (drive_r[c] != '0) drive_nxt[c] = drive_r[c] - DRIVE_W'(1);
              adj_nxt[c] = 1'b1;
            end else if (sp_r[c] > samp[c]) begin
              if (drive_r[c] < DRIVE_TOP) drive_nxt[c] = drive_r[c] + DRIVE_W'(1);
              adj_nxt[c] = 1'b1;
            end else begin
              adj_nxt[c] = 1'b0;
            end
          end
        end
      end
      default: begin
        if (item.bus_address == BUS_ADDR_RUN) begin
          if (item.bus_data[1:0] == RUN_STOP) run_nxt[0] = 1'b0;
          else if (item.bus_data[1:0] == RUN_START) run_nxt[0] = 1'b1;
          if (item.bus_data[3:2] == RUN_STOP) run_nxt[1] = 1'b0;
          else if (item.bus_data[3:2] == RUN_START) run_nxt[1] = 1'b1;
        end else if (item.bus_address == BUS_ADDR_SP0 ||
                     item.bus_address == BUS_ADDR_SP1) begin
          sp_nxt[bus_ch] = (item.bus_data > {{(BUS_W-SP_W){1'b0}}, sp_top_r}) ?
                           sp_top_r : item.bus_data[SP_W-1:0];
          save[bus_ch]   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '{default: '0};
      run_r       <= '0;
      drive_r     <= '{default: '0};
      adj_r       <= '0;
      sel_r       <= 1'b0;
      cyc_r       <= 1'b0;
      blink_r     <= 1'b0;
      blink_cnt_r <= '0;
      idle_cnt_r  <= '0;
    end else if (exec_en) begin
      sp_r        <= sp_nxt;
      run_r       <= run_nxt;
      drive_r     <= drive_nxt;
      adj_r       <= adj_nxt;
      sel_r       <= sel_nxt;
      cyc_r       <= cyc_nxt;
      blink_r     <= blink_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
    end
  end

  always_comb begin
    res.setpoint_out_a = sp_nxt[0];
    res.setpoint_out_b = sp_nxt[1];
    res.running_a      = run_nxt[0];
    res.running_b      = run_nxt[1];
    res.drive_a        = 10'(drive_nxt[0]);
    res.drive_b        = 10'(drive_nxt[1]);
    res.adjusting_a    = adj_nxt[0];
    res.adjusting_b    = adj_nxt[1];
    res.selected       = sel_nxt;
    res.cycling        = cyc_nxt;
    res.phase          = blink_nxt;
    res.save_request   = save;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dcsr_out_stage.sv =====
`default_nettype none
module dcsr_out_stage
  import dcsr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         take,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign take      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dcsr_checker.sv =====
`default_nettype none
module dcsr_checker
  import dcsr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [SP_W-1:0]       out_setpoint_out_a,
  input wire logic [9:0]            out_drive_a,
  input wire logic [9:0]            out_drive_b,
  input wire logic [1:0]            out_save_request
);

  logic out_beat;
  assign out_beat = out_valid && out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_a) &&
      $stable(out_setpoint_out_a) && $stable(out_save_request))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_drive_a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat ##1 out_beat |-> out_drive_a == $past(out_drive_a) ||
      out_drive_a == 10'($past(out_drive_a) + 10'd1) ||
      10'(out_drive_a + 10'd1) == $past(out_drive_a))
    else $error("channel 0 drive moved by more than one");

  a_drive_b_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat ##1 out_beat |-> out_drive_b == $past(out_drive_b) ||
      out_drive_b == 10'($past(out_drive_b) + 10'd1) ||
      10'(out_drive_b + 10'd1) == $past(out_drive_b))
    else $error("channel 1 drive moved by more than one");

endmodule

bind dual_channel_step_regulator_unit dcsr_checker u_dcsr_checker (.*);
`default_nettype wire

// ===== test/tb_dual_channel_step_regulator_unit.sv =====
`default_nettype none
module tb_dual_channel_step_regulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dcsr_pkg::*;

  localparam int DRIVE_TOP = 1023;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;

  class regulator_scoreboard;
    logic [CNT_W-1:0] blink_period;
    logic [CNT_W-1:0] cycle_delay;
    logic [SP_W-1:0]  sp_top;
    logic [SP_W-1:0]  sp [2];
    logic             run [2];
    int unsigned      drv [2];
    logic             adj [2];
    logic             sel;
    logic             cyc;
    logic             blink;
    logic [CNT_W-1:0] blink_cnt;
    logic [CNT_W-1:0] idle_cnt;
    result_t          expected_status_q[$];
    int unsigned      fail_count;

    function void restart();
      blink_period = BLINK_PERIOD_RST;
      cycle_delay = AUTO_DELAY_RST;
      sp_top = SP_TOP_RST;
      for (int i = 0; i < 2; i++) begin
        sp[i] = '0;
        run[i] = 1'b0;
        drv[i] = 0;
        adj[i] = 1'b0;
      end
      sel = 1'b0;
      cyc = 1'b0;
      blink = 1'b0;
      blink_cnt = '0;
      idle_cnt = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BLINK_PERIOD: blink_period = val;
        REG_AUTO_DELAY:   cycle_delay = val;
        REG_SP_TOP:       sp_top = val[SP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction

    function void step_drive(int ch, logic [SAMP_W-1:0] samp);
      if (!run[ch]) return;
      if (sp[ch] < samp) begin
        if (drv[ch] > 0) drv[ch]--;
        adj[ch] = 1'b1;
      end else if (sp[ch] > samp) begin
        if (drv[ch] < DRIVE_TOP) drv[ch]++;
        adj[ch] = 1'b1;
      end else begin
        adj[ch] = 1'b0;
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      logic [CNT_W:0] nxt;
      logic [1:0] save;
      logic ch;
      save = '0;
      case (it.kind)
        KIND_TICK: begin
          nxt = {1'b0, blink_cnt} + 1'b1;
          if (nxt > {1'b0, blink_period}) begin
            blink_cnt = '0;
            blink = ~blink;
          end else begin
            blink_cnt = nxt[CNT_W-1:0];
          end
          if (run[0] && run[1] && !cyc) begin
            nxt = {1'b0, idle_cnt} + 1'b1;
            if (nxt > {1'b0, cycle_delay}) begin
              cyc = 1'b1;
              idle_cnt = '0;
            end else begin
              idle_cnt = nxt[CNT_W-1:0];
            end
          end
        end
        KIND_KEY: begin
          ch = sel;
          if (cyc) begin
            cyc = 1'b0;
          end else begin
            idle_cnt = '0;
            case (it.key_code)
              KEY_SEL: sel = ~sel;
              KEY_UP: begin
                if (sp[ch] < sp_top) begin
                  sp[ch] = sp[ch] + 1'b1;
                  save[ch] = 1'b1;
                end
              end
              KEY_DN: begin
                if (sp[ch] != '0) begin
                  sp[ch] = sp[ch] - 1'b1;
                  save[ch] = 1'b1;
                end
              end
              default: run[ch] = ~run[ch];
            endcase
          end
        end
        KIND_REG: begin
          step_drive(0, it.sample_a);
          step_drive(1, it.sample_b);
        end
        default: begin
          if (it.bus_address == BUS_ADDR_RUN) begin
            if (it.bus_data[1:0] == RUN_STOP) run[0] = 1'b0;
            else if (it.bus_data[1:0] == RUN_START) run[0] = 1'b1;
            if (it.bus_data[3:2] == RUN_STOP) run[1] = 1'b0;
            else if (it.bus_data[3:2] == RUN_START) run[1] = 1'b1;
          end else if (it.bus_address == BUS_ADDR_SP0 || it.bus_address == BUS_ADDR_SP1) begin
            ch = (it.bus_address == BUS_ADDR_SP1);
            sp[ch] = (it.bus_data > {6'd0, sp_top}) ? sp_top : it.bus_data[SP_W-1:0];
            save[ch] = 1'b1;
          end
        end
      endcase
      r = '{sp[0], sp[1], run[0], run[1], 10'(drv[0]), 10'(drv[1]), adj[0], adj[1],
            sel, cyc, blink, save};
      expected_status_q.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("sp=%0d/%0d run=%b%b drv=%0d/%0d adj=%b%b sel=%b cyc=%b ph=%b save=%b",
                       r.setpoint_out_a, r.setpoint_out_b, r.running_a, r.running_b,
                       r.drive_a, r.drive_b, r.adjusting_a, r.adjusting_b, r.selected,
                       r.cycling, r.phase, r.save_request);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      string diff;
      if (expected_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result beat with nothing expected: %s", $time, show(got));
        return;
      end
      want = expected_status_q.pop_front();
      diff = "";
      if (got.setpoint_out_a !== want.setpoint_out_a) diff = {diff, " setpoint_out_a"};
      if (got.setpoint_out_b !== want.setpoint_out_b) diff = {diff, " setpoint_out_b"};
      if (got.running_a !== want.running_a) diff = {diff, " running_a"};
      if (got.running_b !== want.running_b) diff = {diff, " running_b"};
      if (got.drive_a !== want.drive_a) diff = {diff, " drive_a"};
      if (got.drive_b !== want.drive_b) diff = {diff, " drive_b"};
      if (got.adjusting_a !== want.adjusting_a) diff = {diff, " adjusting_a"};
      if (got.adjusting_b !== want.adjusting_b) diff = {diff, " adjusting_b"};
      if (got.selected !== want.selected) diff = {diff, " selected"};
      if (got.cycling !== want.cycling) diff = {diff, " cycling"};
      if (got.phase !== want.phase) diff = {diff, " phase"};
      if (got.save_request !== want.save_request) diff = {diff, " save_request"};
      if (diff != "") begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                   $time, diff, show(want), show(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_kind;
  logic [1:0] in_key_code;
  logic [SAMP_W-1:0] in_sample_a;
  logic [SAMP_W-1:0] in_sample_b;
  logic [BUS_W-1:0] in_bus_address;
  logic [BUS_W-1:0] in_bus_data;
  logic out_valid;
  logic out_ready;
  logic [SP_W-1:0] out_setpoint_out_a;
  logic [SP_W-1:0] out_setpoint_out_b;
  logic out_running_a;
  logic out_running_b;
  logic [9:0] out_drive_a;
  logic [9:0] out_drive_b;
  logic out_adjusting_a;
  logic out_adjusting_b;
  logic out_selected;
  logic out_cycling;
  logic out_phase;
  logic [1:0] out_save_request;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  regulator_scoreboard sb;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;

  dual_channel_step_regulator_unit #(.DRIVE_MAX(DRIVE_TOP)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_key_code(in_key_code),
    .in_sample_a(in_sample_a),
    .in_sample_b(in_sample_b),
    .in_bus_address(in_bus_address),
    .in_bus_data(in_bus_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_setpoint_out_a(out_setpoint_out_a),
    .out_setpoint_out_b(out_setpoint_out_b),
    .out_running_a(out_running_a),
    .out_running_b(out_running_b),
    .out_drive_a(out_drive_a),
    .out_drive_b(out_drive_b),
    .out_adjusting_a(out_adjusting_a),
    .out_adjusting_b(out_adjusting_b),
    .out_selected(out_selected),
    .out_cycling(out_cycling),
    .out_phase(out_phase),
    .out_save_request(out_save_request),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dual_channel_step_regulator_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = '{out_setpoint_out_a, out_setpoint_out_b, out_running_a, out_running_b,
              out_drive_a, out_drive_b, out_adjusting_a, out_adjusting_b,
              out_selected, out_cycling, out_phase, out_save_request};
      sb.check_beat(got);
    end
  end

  // result side: rotating stall patterns, plus one long hold-off on request
  initial begin : receiver
    logic [15:0] pattern;
    int unsigned left;
    out_ready <= 1'b0;
    pattern = '1;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom);
            2: pattern = 16'($urandom) | 16'($urandom);
            default: pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
          endcase
        end
        out_ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
        left--;
      end
    end
  end

  function automatic item_t mk(input logic [1:0] kind, input logic [1:0] key,
                               input logic [SAMP_W-1:0] sa, input logic [SAMP_W-1:0] sbv,
                               input logic [BUS_W-1:0] addr, input logic [BUS_W-1:0] data);
    item_t it;
    it = '{kind, key, sa, sbv, addr, data};
    return it;
  endfunction

  function automatic logic [SAMP_W-1:0] near_level(input logic [SP_W-1:0] level);
    int v;
    v = int'(level) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMP_W'(v);
  endfunction

  function automatic item_t rand_item(input int unsigned tick_w);
    item_t it;
    int unsigned r;
    int unsigned rest;
    it = mk(KIND_TICK, 2'($urandom), SAMP_W'($urandom), SAMP_W'($urandom),
            BUS_W'($urandom), BUS_W'($urandom));
    r = $urandom_range(0, 99);
    rest = (100 - tick_w) / 3;
    if (r < tick_w) it.kind = KIND_TICK;
    else if (r < tick_w + rest) it.kind = KIND_KEY;
    else if (r < tick_w + 2 * rest) it.kind = KIND_REG;
    else it.kind = KIND_BUS;
    case (it.kind)
      KIND_REG: begin
        if ($urandom_range(0, 2) != 0) it.sample_a = near_level(sb.sp[0]);
        if ($urandom_range(0, 2) != 0) it.sample_b = near_level(sb.sp[1]);
      end
      KIND_BUS: begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          it.bus_address = BUS_ADDR_RUN;
        end else if (r < 9) begin
          it.bus_address = r[0] ? BUS_ADDR_SP0 : BUS_ADDR_SP1;
          if ($urandom_range(0, 3) != 0) it.bus_data = BUS_W'($urandom_range(0, 1100));
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic push_item(input item_t it);
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_key_code <= it.key_code;
    in_sample_a <= it.sample_a;
    in_sample_b <= it.sample_b;
    in_bus_address <= it.bus_address;
    in_bus_data <= it.bus_data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic idle_in(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] delay,
                              input logic [SP_W-1:0] top);
    logic [CFG_IDX_W-1:0] regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{REG_BLINK_PERIOD, REG_AUTO_DELAY, REG_SP_TOP};
    vals = '{period, delay, {6'd0, top}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned tick_w);
    int unsigned burst;
    burst = 0;
    repeat (n) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 6));
      end
      push_item(rand_item(tick_w));
      burst--;
    end
  endtask

  initial begin
    sb = new();
    sb.restart();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_TICK;
    in_key_code <= KEY_SEL;
    in_sample_a <= '0;
    in_sample_b <= '0;
    in_bus_address <= '0;
    in_bus_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BLINK_PERIOD;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: keys, clamping, run control patterns, regulation edges
    push_item(mk(KIND_TICK, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_UP, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_DN, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_DN, '1, '1, '1, '1));
    push_item(mk(KIND_KEY, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP1, 16'hFFFF));
    push_item(mk(KIND_KEY, KEY_UP, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_RUN, '0, '0, '0, '0));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP0, 16'h0123));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'hFFF2));
    push_item(mk(KIND_REG, KEY_SEL, 10'd1023, 10'd0, '0, '0));
    push_item(mk(KIND_REG, KEY_SEL, 10'd291, 10'd500, '0, '0));
    push_item(mk(KIND_REG, KEY_SEL, 10'd0, 10'd1023, '0, '0));
    push_item(mk(KIND_BUS, KEY_RUN, '1, '1, 16'hFFFF, 16'hFFFF));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'h0005));
    push_item(mk(KIND_REG, KEY_SEL, 10'd1023, 10'd1023, '0, '0));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'h000F));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'h0008));
    push_item(mk(KIND_KEY, KEY_RUN, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, 16'd3, 16'h0001));
    push_item(mk(KIND_TICK, KEY_SEL, '0, '0, '0, '0));
    settle();

    // period and delay of one: auto-cycle entry, then a key that only leaves it
    program_regs(16'd1, 16'd1, 10'd1023);
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'h000A));
    push_item(mk(KIND_TICK, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_TICK, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_TICK, KEY_SEL, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_UP, '0, '0, '0, '0));
    push_item(mk(KIND_KEY, KEY_UP, '0, '0, '0, '0));
    run_random(100, 50);
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP0, 16'd900));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP1, 16'd900));
    settle();

    // top of zero leaves setpoints above it
    program_regs(16'hFFFF, 16'hFFFF, 10'd0);
    run_random(80, 20);
    settle();

    // drive ramp to the upper saturation end under a long result-side hold
    program_regs(16'd3, 16'd5, 10'd1023);
    hold_req = 1'b1;
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP0, 16'd1023));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_SP1, 16'd1023));
    push_item(mk(KIND_BUS, KEY_SEL, '0, '0, BUS_ADDR_RUN, 16'h000A));
    repeat (1030)
      push_item(mk(KIND_REG, 2'($urandom), SAMP_W'($urandom_range(0, 1022)),
                   SAMP_W'($urandom_range(0, 1022)), BUS_W'($urandom), BUS_W'($urandom)));
    repeat (4) push_item(mk(KIND_REG, KEY_SEL, 10'd1023, 10'd1023, '0, '0));
    settle();

    program_regs(16'($urandom_range(1, 9)), 16'($urandom_range(1, 40)),
                 SP_W'($urandom_range(0, 1023)));
    run_random(80, 40);
    settle();

    program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 SP_W'($urandom));
    run_random(80, 30);
    settle();

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb_dual_channel_step_regulator_unit: PASS");
    end else begin
      $display("tb_dual_channel_step_regulator_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
